// ----- hw/rtl/ssls_pkg.sv -----
package ssls_pkg;

    localparam int unsigned LEN_W  = 26;  // max segment length 60074666 ms
    localparam int unsigned DIVD_W = 21;  // spiral numerator fits in 21 bits
    localparam int unsigned IDX_W  = 16;

    localparam logic [DIVD_W-1:0] SPIRAL_NUM     = 21'd1728100;  // 1571 * 1100
    localparam logic [5:0]        SEARCH_SPEED   = 6'd60;
    localparam logic [5:0]        STEER_SPEED    = 6'd30;
    localparam logic [3:0]        BUMP_THRESHOLD = 4'd5;
    localparam logic [3:0]        BUMP_RUN_MAX   = 4'd15;
    localparam logic [10:0]       SEG_MS_PER_K   = 11'd1833;     // 5500 / 3, integer part
    localparam logic [15:0]       RECIP_THREE    = 16'd43691;    // ceil(2^17 / 3)
    localparam logic signed [13:0] QUARTER_PI_MRAD = 14'sd785;

    localparam logic [2:0] REG_FR_OFFSET  = 3'd0;
    localparam logic [2:0] REG_RR_OFFSET  = 3'd1;
    localparam logic [2:0] REG_NEAR_LIMIT = 3'd2;
    localparam logic [2:0] REG_TURN_GAIN  = 3'd3;
    localparam logic [2:0] REG_TURN_LIMIT = 3'd4;

    typedef struct packed {
        logic [9:0]  fr_off;
        logic [9:0]  rr_off;
        logic [11:0] near_lim;
        logic [3:0]  gain;
        logic [11:0] turn_lim;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_start;
        logic turn_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic seg_end;
        logic div_busy;
        logic div_done;
    } sts_t;

endpackage

// ----- hw/rtl/ssls_div.sv -----
module ssls_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ssls_pkg::LEN_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [ssls_pkg::DIVD_W-1:0] quotient
);
    import ssls_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVD_W);

    logic [LEN_W-1:0]  dvs_reg;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    diff;

    // restoring division, one quotient bit per cycle; quo_reg shifts the
    // dividend out at the top and the quotient in at the bottom
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = SPIRAL_NUM;
            cnt_next  = CNT_W'(DIVD_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[LEN_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[LEN_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/ssls_dp.sv -----
module ssls_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssls_pkg::cmd_t       cmd,
    input  ssls_pkg::cfg_t       cfg,
    input  logic [31:0]          now_ms,
    input  logic [7:0]           bump_bits,
    input  logic [11:0]          light_front_right,
    input  logic [11:0]          light_front_left,
    input  logic [11:0]          light_rear_left,
    input  logic [11:0]          light_rear_right,
    output ssls_pkg::sts_t       sts,
    output logic [5:0]           forward_speed,
    output logic signed [12:0]   turn_rate,
    output logic                 task_done,
    output logic                 steering_mode
);
    import ssls_pkg::*;

    // captured word
    logic [31:0] now_reg;
    logic        bumped_reg;
    logic [11:0] fr_raw_reg, fl_raw_reg, rl_raw_reg, rr_raw_reg;

    // controller state
    logic             mode_reg;
    logic [3:0]       bump_run_reg, bump_run_next;
    logic [IDX_W-1:0] index_reg;
    logic [31:0]      start_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             done_reg;
    logic signed [12:0] spiral_turn_reg;

    // result of this tick
    logic [5:0]         res_speed_reg;
    logic signed [12:0] res_turn_reg;
    logic               res_mode_reg;

    // output word
    logic [5:0]         out_speed_reg;
    logic signed [12:0] out_turn_reg;
    logic               out_done_reg;
    logic               out_mode_reg;

    logic signed [12:0] fr_c, fl_c, rl_c, rr_c;
    logic signed [12:0] rear_min, front_max;
    logic [12:0]        lim;
    logic               all_near;
    logic signed [13:0] diff;
    logic signed [18:0] diff_x, gain_x, prod, tl, clamped;
    logic signed [12:0] steer_turn;
    logic [31:0]        seg_sum;
    logic               seg_end;
    logic [IDX_W:0]     idx_p1;
    logic [IDX_W-1:0]   k;
    logic [31:0]        third;
    logic [LEN_W-1:0]   len_base;

    logic                div_busy, div_done;
    logic [DIVD_W-1:0]   quotient;
    logic signed [12:0]  new_turn;

    function automatic logic [12:0] mag13(input logic signed [12:0] v);
        return v[12] ? 13'(-v) : 13'(v);
    endfunction

    always_comb
    begin
        fr_c = $signed({1'b0, fr_raw_reg}) - $signed({3'b000, cfg.fr_off});
        fl_c = $signed({1'b0, fl_raw_reg});
        rl_c = $signed({1'b0, rl_raw_reg});
        rr_c = $signed({1'b0, rr_raw_reg}) - $signed({3'b000, cfg.rr_off});
        lim  = {1'b0, cfg.near_lim};
        all_near = (mag13(fr_c) < lim) && (mag13(fl_c) < lim)
                && (mag13(rl_c) < lim) && (mag13(rr_c) < lim);

        rear_min  = (rl_c < rr_c) ? rl_c : rr_c;
        front_max = (fl_c > fr_c) ? fl_c : fr_c;
        if (rear_min > front_max)
        begin
            diff = QUARTER_PI_MRAD;
        end
        else
        begin
            diff = 14'(fl_c) - 14'(fr_c);
        end

        diff_x = 19'(diff);
        gain_x = $signed({15'd0, cfg.gain});
        prod   = diff_x * gain_x;
        tl     = $signed({7'd0, cfg.turn_lim});
        if (prod > tl)
        begin
            clamped = tl;
        end
        else if (prod < -tl)
        begin
            clamped = -tl;
        end
        else
        begin
            clamped = prod;
        end
        steer_turn = clamped[12:0];

        seg_sum = start_reg + {{(32 - LEN_W){1'b0}}, len_reg};
        seg_end = !mode_reg && (now_reg >= seg_sum);

        if (bumped_reg)
        begin
            bump_run_next = (bump_run_reg == BUMP_RUN_MAX) ? bump_run_reg
                                                           : bump_run_reg + 1'b1;
        end
        else
        begin
            bump_run_next = '0;
        end

        // length = floor(k * 5500 / 3) = 1833 * k + floor(k / 3)
        idx_p1   = {1'b0, index_reg} + 1'b1;
        k        = idx_p1[IDX_W:1];
        third    = {16'd0, k} * {16'd0, RECIP_THREE};
        len_base = LEN_W'({10'd0, k} * {15'd0, SEG_MS_PER_K});
        len_next = len_base + {{(LEN_W - 15){1'b0}}, third[31:17]};

        new_turn = (len_reg == '0) ? 13'sd0 : $signed(quotient[12:0]);
    end

    ssls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (len_next),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            bump_run_reg    <= '0;
            index_reg       <= '0;
            start_reg       <= '0;
            len_reg         <= '0;
            done_reg        <= 1'b0;
            spiral_turn_reg <= '0;
        end
        else
        begin
            if (cmd.eval)
            begin
                bump_run_reg <= bump_run_next;
                if (!mode_reg)
                begin
                    if (bump_run_next > BUMP_THRESHOLD)
                    begin
                        mode_reg <= 1'b1;
                    end
                    if (seg_end)
                    begin
                        if (index_reg != {IDX_W{1'b1}})
                        begin
                            index_reg <= index_reg + 1'b1;
                        end
                        start_reg <= now_reg;
                    end
                end
                else
                begin
                    done_reg <= !all_near;
                end
            end
            if (cmd.div_start)
            begin
                len_reg <= len_next;
            end
            if (cmd.turn_load)
            begin
                spiral_turn_reg <= new_turn;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg    <= now_ms;
            bumped_reg <= (bump_bits != '0);
            fr_raw_reg <= light_front_right;
            fl_raw_reg <= light_front_left;
            rl_raw_reg <= light_rear_left;
            rr_raw_reg <= light_rear_right;
        end
        if (cmd.eval)
        begin
            res_mode_reg <= mode_reg;
            if (!mode_reg)
            begin
                res_speed_reg <= SEARCH_SPEED;
                res_turn_reg  <= spiral_turn_reg;
            end
            else if (all_near)
            begin
                res_speed_reg <= STEER_SPEED;
                res_turn_reg  <= steer_turn;
            end
            else
            begin
                res_speed_reg <= '0;
                res_turn_reg  <= '0;
            end
        end
        if (cmd.turn_load)
        begin
            res_turn_reg <= new_turn;
        end
        if (cmd.out_load)
        begin
            out_speed_reg <= res_speed_reg;
            out_turn_reg  <= res_turn_reg;
            out_done_reg  <= done_reg;
            out_mode_reg  <= res_mode_reg;
        end
    end

    assign sts.seg_end  = seg_end;
    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;

    assign forward_speed = out_speed_reg;
    assign turn_rate     = out_turn_reg;
    assign task_done     = out_done_reg;
    assign steering_mode = out_mode_reg;

endmodule

// ----- hw/rtl/ssls_ctrl.sv -----
module ssls_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  ssls_pkg::sts_t sts,
    output ssls_pkg::cmd_t cmd
);
    import ssls_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_LEN  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.seg_end ? ST_LEN : ST_OUT;
            end
            ST_LEN:
            begin
                // new length is registered and handed to the divider together
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.turn_load = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/spiral_search_light_steer_top.sv -----
// Spiral search / light steering controller. Each input word is one control
// tick and yields one output word. A tick is captured, evaluated and then
// loaded into the output register; a search tick ending a spiral segment
// also waits on the 21-step serial divider forming the new spiral turn rate.
// The output register lets the next word be accepted while a result waits.
// Configuration registers sit on the APB port at byte offsets 0x00..0x10:
// front right offset, rear right offset, near limit, turn gain, turn limit.
module spiral_search_light_steer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        now_ms,
    input  logic [7:0]         bump_bits,
    input  logic [11:0]        light_front_right,
    input  logic [11:0]        light_front_left,
    input  logic [11:0]        light_rear_left,
    input  logic [11:0]        light_rear_right,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         forward_speed,
    output logic signed [12:0] turn_rate,
    output logic               task_done,
    output logic               steering_mode
);
    import ssls_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    sts_t       sts;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fr_off   <= 10'd90;
            cfg_reg.rr_off   <= 10'd0;
            cfg_reg.near_lim <= 12'd1200;
            cfg_reg.gain     <= 4'd5;
            cfg_reg.turn_lim <= 12'd4000;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_FR_OFFSET:  cfg_reg.fr_off   <= pwdata[9:0];
                REG_RR_OFFSET:  cfg_reg.rr_off   <= pwdata[9:0];
                REG_NEAR_LIMIT: cfg_reg.near_lim <= pwdata[11:0];
                REG_TURN_GAIN:  cfg_reg.gain     <= pwdata[3:0];
                REG_TURN_LIMIT: cfg_reg.turn_lim <= pwdata[11:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FR_OFFSET:  prdata = {22'd0, cfg_reg.fr_off};
            REG_RR_OFFSET:  prdata = {22'd0, cfg_reg.rr_off};
            REG_NEAR_LIMIT: prdata = {20'd0, cfg_reg.near_lim};
            REG_TURN_GAIN:  prdata = {28'd0, cfg_reg.gain};
            REG_TURN_LIMIT: prdata = {20'd0, cfg_reg.turn_lim};
            default:        prdata = '0;
        endcase
    end

    ssls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ssls_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg_reg),
        .now_ms            (now_ms),
        .bump_bits         (bump_bits),
        .light_front_right (light_front_right),
        .light_front_left  (light_front_left),
        .light_rear_left   (light_rear_left),
        .light_rear_right  (light_rear_right),
        .sts               (sts),
        .forward_speed     (forward_speed),
        .turn_rate         (turn_rate),
        .task_done         (task_done),
        .steering_mode     (steering_mode)
    );

    // one tick at a time: no new word right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a tick is in progress");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> sts.div_busy)
        else $error("divider did not start");

    a_search_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !steering_mode |-> forward_speed == SEARCH_SPEED && !task_done)
        else $error("search word with wrong speed or done flag");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && task_done |-> forward_speed == '0 && turn_rate == '0)
        else $error("done word still moving");

endmodule
